>>> hdl/lfsf_pkg.sv
// Shared widths, reset values and register codes for the largest free square finder.
package lfsf_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned RowWidthW = 11;
  localparam int unsigned RowCountW = 16;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned ColW      = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutFieldW = SizeW + RowCountW + ColW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam int unsigned DefMaxWidth = 1024;

  localparam logic [RowWidthW-1:0] RowWidthRst = RowWidthW'(1);
  localparam logic [RowCountW-1:0] RowCountRst = RowCountW'(1);
  localparam logic [CharW-1:0]     ObstacleRst = CharW'(111);

  typedef enum logic [CfgIdxW-1:0] {
    RegRowWidth    = 2'd0,
    RegRowCount    = 2'd1,
    RegObstacleChr = 2'd2
  } reg_idx_e;

endpackage

>>> hdl/lfsf_ram.sv
// Simple dual-port RAM, one write and one registered read port, read-first.
module lfsf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/largest_free_square_finder_core.sv
// Top level of the largest free square finder: row-buffer scoring over a cell stream.
//
// Usage:
//   Cells of a character grid enter on the s_axis request channel in raster
//   order, one character per request. Each cell is scored (0 for an obstacle,
//   1 on the first row or column, else 1 + min of up, left and up-left), and
//   the first cell with the largest score is tracked. After the last cell of
//   the grid (row_width x row_count, set through the cfg port) one result
//   request leaves on m_axis: square size and bottom-right row and column.
//   Throughput is one cell per cycle but for a waiting last cell; the single
//   row-buffer RAM is read when a cell is accepted and written back the next
//   cycle, with a bypass for a one-column grid. m_axis_tvalid comes from the
//   head result register, loaded from the scoring stage. Two result registers
//   absorb a stalled receiver; cells keep flowing, and a last cell waits only
//   while both result slots may still be taken when it gets scored.
//   Reset clears positions, scores and the best entry; registers return to
//   width 1, count 1, obstacle character 111. The row RAM needs no clearing.
//   Configuration must be written only while the block is idle; the block does not enforce this.
module largest_free_square_finder_core #(
  parameter int unsigned MAX_WIDTH = lfsf_pkg::DefMaxWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write port
  input  logic                          cfg_we_i,
  input  logic [lfsf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfsf_pkg::CfgDataW-1:0] cfg_wdata_i,
  // cell input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lfsf_pkg::CharW-1:0]    s_axis_tdata,   // [7:0] cell_char
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [10:0] square_size, [26:11] corner_row, [36:27] corner_col, [39:37] zero
  output logic [lfsf_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW = (CW + 1 > lfsf_pkg::RowWidthW) ? CW + 1 : lfsf_pkg::RowWidthW;
  localparam int unsigned RW = lfsf_pkg::RowCountW;

  // configuration registers
  logic [lfsf_pkg::RowWidthW-1:0] row_width_q;
  logic [RW-1:0]                  row_count_q;
  logic [lfsf_pkg::CharW-1:0]     obstacle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= lfsf_pkg::RowWidthRst;
      row_count_q <= lfsf_pkg::RowCountRst;
      obstacle_q  <= lfsf_pkg::ObstacleRst;
    end else if (cfg_we_i) begin
      case (lfsf_pkg::reg_idx_e'(cfg_idx_i))
        lfsf_pkg::RegRowWidth:    row_width_q <= cfg_wdata_i[lfsf_pkg::RowWidthW-1:0];
        lfsf_pkg::RegRowCount:    row_count_q <= cfg_wdata_i[RW-1:0];
        lfsf_pkg::RegObstacleChr: obstacle_q  <= cfg_wdata_i[lfsf_pkg::CharW-1:0];
        default: ;
      endcase
    end
  end

  // scan position of the next cell
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic [EW-1:0] rw_ext, eff_width, col_next;
  logic [RW:0]   eff_count, row_next;
  logic          row_end, grid_end;

  assign rw_ext    = EW'(row_width_q);
  assign eff_width = (row_width_q == '0) ? EW'(1) :
                     ((rw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : rw_ext);
  assign col_next  = EW'(col_q) + EW'(1);
  assign row_end   = col_next >= eff_width;
  assign eff_count = (row_count_q == '0) ? (RW+1)'(1) : {1'b0, row_count_q};
  assign row_next  = {1'b0, row_q} + (RW+1)'(1);
  assign grid_end  = row_end && (row_next >= eff_count);

  // scoring stage
  logic          b_valid_q, b_free_q, b_edge_q, b_top_q, b_rowend_q, b_last_q, b_fwd_q;
  logic [CW-1:0] b_col_q;
  logic [RW-1:0] b_row_q;

  logic          out_valid_q, skd_valid_q;
  logic          accept;
  logic [1:0]    res_held;

  // results still held after this edge, counting the one in the scoring stage
  assign res_held = 2'(out_valid_q) + 2'(skd_valid_q) + 2'(b_valid_q && b_last_q)
                    - 2'(out_valid_q && m_axis_tready);
  // last cell waits unless a result slot is sure to be free when it is scored
  assign s_axis_tready = !(grid_end && res_held[1]);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (!row_end) begin
        col_q <= col_next[CW-1:0];
      end else if (grid_end) begin
        col_q <= '0;
        row_q <= '0;
      end else begin
        col_q <= '0;
        row_q <= row_next[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q    <= col_q;
      b_row_q    <= row_q;
      b_free_q   <= s_axis_tdata != obstacle_q;
      b_edge_q   <= (row_q == '0) || (col_q == '0);
      b_top_q    <= row_q != '0;
      b_rowend_q <= row_end;
      b_last_q   <= grid_end;
      // same entry is being written back this cycle: the RAM read sees stale data
      b_fwd_q    <= b_valid_q && (b_col_q == col_q);
    end
  end

  // row buffer
  logic [SW-1:0] rd_data, score;

  lfsf_ram #(
    .Width (SW),
    .Depth (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (score),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  logic [SW-1:0] left_q, diag_q, last_score_q;
  logic [SW-1:0] best_size_q;
  logic [RW-1:0] best_row_q;
  logic [CW-1:0] best_col_q;

  logic [SW-1:0] up, min_lu, min3;
  logic [SW:0]   inc;
  logic          better;

  always_comb begin
    up     = !b_top_q ? '0 : (b_fwd_q ? last_score_q : rd_data);
    min_lu = (left_q < up) ? left_q : up;
    min3   = (diag_q < min_lu) ? diag_q : min_lu;
    inc    = {1'b0, min3} + (SW+1)'(1);
    if (!b_free_q) begin
      score = '0;
    end else if (b_edge_q) begin
      score = SW'(1);
    end else if (inc > (SW+1)'(MAX_WIDTH)) begin
      score = SW'(MAX_WIDTH);
    end else begin
      score = inc[SW-1:0];
    end
    better = score > best_size_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      diag_q       <= '0;
      last_score_q <= '0;
      best_size_q  <= '0;
      best_row_q   <= '0;
      best_col_q   <= '0;
    end else if (b_valid_q) begin
      last_score_q <= score;
      left_q       <= b_rowend_q ? '0 : score;
      diag_q       <= b_rowend_q ? '0 : up;
      if (b_last_q) begin
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else if (better) begin
        best_size_q <= score;
        best_row_q  <= b_row_q;
        best_col_q  <= b_col_q;
      end
    end
  end

  // result registers: head drives m_axis, second slot takes a result while head waits
  logic                           out_load, out_pop;
  logic [lfsf_pkg::OutFieldW-1:0] res_word, out_res_q, skd_res_q;

  assign out_load = b_valid_q && b_last_q;
  assign out_pop  = out_valid_q && m_axis_tready;
  assign res_word = better ?
      {lfsf_pkg::ColW'(b_col_q), b_row_q, lfsf_pkg::SizeW'(score)} :
      {lfsf_pkg::ColW'(best_col_q), best_row_q, lfsf_pkg::SizeW'(best_size_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skd_valid_q <= 1'b0;
    end else if (!out_valid_q || out_pop) begin
      out_valid_q <= skd_valid_q || out_load;
      skd_valid_q <= skd_valid_q && out_load;
    end else if (out_load) begin
      skd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      skd_res_q <= res_word;
    end
    if (!out_valid_q || out_pop) begin
      out_res_q <= skd_valid_q ? skd_res_q : res_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(lfsf_pkg::OutDataW - lfsf_pkg::OutFieldW)'(0), out_res_q};

  // checks
  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!skd_valid_q || m_axis_tready))
    else $error("result overwrote a pending result");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_last_q) |-> (col_q == '0 && row_q == '0))
    else $error("scan position not restarted after last cell");

  a_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_last_q) |=> (best_size_q >= $past(best_size_q)))
    else $error("best size decreased inside a grid");

  a_size_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_res_q[lfsf_pkg::SizeW-1:0] <= lfsf_pkg::SizeW'(MAX_WIDTH)))
    else $error("square size above limit");

endmodule
